[hdl/vsp_pkg.sv]
package vsp_pkg;

    localparam int OUT_W = 31;
    localparam int DATA_W = 128;
    localparam int USER_W = 2;

    localparam logic [3:0] PH_MAJOR       = 4'd0;
    localparam logic [3:0] PH_MINOR       = 4'd1;
    localparam logic [3:0] PH_PATCH       = 4'd2;
    localparam logic [3:0] PH_SUFFIX      = 4'd3;
    localparam logic [3:0] PH_STABLE      = 4'd4;
    localparam logic [3:0] PH_BETA_LIT    = 4'd5;
    localparam logic [3:0] PH_BETA_NUM    = 4'd6;
    localparam logic [3:0] PH_DONE_STABLE = 4'd7;
    localparam logic [3:0] PH_FAIL        = 4'd8;

    localparam logic [2:0] STABLE_LEN = 3'd6;
    localparam logic [2:0] BETA_LEN   = 3'd5;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_DASH = 8'h2d;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] lit_idx;
        logic       saw_digit;
    } t_ctl;

    function automatic logic [7:0] stable_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h73;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h61;
            3'd3:    c = 8'h62;
            3'd4:    c = 8'h6c;
            3'd5:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] beta_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h2e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hdl/vsp_digit.sv]
module vsp_digit import vsp_pkg::*; #(
    parameter int NUM_BITS = 31
) (
    input  logic [NUM_BITS-1:0] i_accum,
    input  logic [7:0]          i_char,
    output logic [NUM_BITS-1:0] o_value,
    output logic                o_ovf
);

    logic [NUM_BITS+3:0] w_times10;
    logic [NUM_BITS+3:0] w_sum;
    logic [7:0]          w_digit;

    // accum * 10 as (accum << 3) + (accum << 1)
    assign w_times10 = {1'b0, i_accum, 3'b000} + {3'b000, i_accum, 1'b0};
    assign w_digit   = i_char - CH_ZERO;
    assign w_sum     = w_times10 + {{(NUM_BITS-4){1'b0}}, w_digit};
    assign o_value   = w_sum[NUM_BITS-1:0];
    assign o_ovf     = |w_sum[NUM_BITS+3:NUM_BITS];

endmodule

[hdl/vsp_step.sv]
module vsp_step import vsp_pkg::*; #(
    parameter int NUM_BITS = 31
) (
    input  t_ctl                i_ctl,
    input  logic [NUM_BITS-1:0] i_accum,
    input  logic [NUM_BITS-1:0] i_major,
    input  logic [NUM_BITS-1:0] i_minor,
    input  logic [NUM_BITS-1:0] i_patch,
    input  logic [7:0]          i_char,
    input  logic                i_last,
    output t_ctl                o_ctl,
    output logic [NUM_BITS-1:0] o_accum,
    output logic [NUM_BITS-1:0] o_major,
    output logic [NUM_BITS-1:0] o_minor,
    output logic [NUM_BITS-1:0] o_patch,
    output logic [DATA_W-1:0]   o_data,
    output logic [USER_W-1:0]   o_user
);

    logic [NUM_BITS-1:0] w_dval;
    logic                w_ovf;
    logic                w_is_digit;
    logic                w_num_phase;
    logic [7:0]          w_sep;
    t_ctl                w_ctl;
    logic [NUM_BITS-1:0] w_accum;
    logic [NUM_BITS-1:0] w_major;
    logic [NUM_BITS-1:0] w_minor;
    logic [NUM_BITS-1:0] w_patch;
    logic                w_ok_stable;
    logic                w_ok_beta;
    logic [NUM_BITS+OUT_W-1:0] w_ext_major;
    logic [NUM_BITS+OUT_W-1:0] w_ext_minor;
    logic [NUM_BITS+OUT_W-1:0] w_ext_patch;
    logic [NUM_BITS+OUT_W-1:0] w_ext_beta;
    logic [OUT_W-1:0]    w_out_beta;

    vsp_digit #(.NUM_BITS(NUM_BITS)) u_digit (
        .i_accum (i_accum),
        .i_char  (i_char),
        .o_value (w_dval),
        .o_ovf   (w_ovf)
    );

    assign w_is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_num_phase = (i_ctl.phase == PH_MAJOR) || (i_ctl.phase == PH_MINOR)
                      || (i_ctl.phase == PH_PATCH) || (i_ctl.phase == PH_BETA_NUM);
    assign w_sep       = (i_ctl.phase == PH_PATCH) ? CH_DASH : CH_DOT;

    always_comb begin
        w_ctl   = i_ctl;
        w_accum = i_accum;
        w_major = i_major;
        w_minor = i_minor;
        w_patch = i_patch;
        if (w_num_phase && w_is_digit) begin
            if (w_ovf) begin
                w_ctl.phase = PH_FAIL;
            end else begin
                w_accum       = w_dval;
                w_ctl.saw_digit = 1'b1;
            end
        end else if (w_num_phase && i_ctl.phase != PH_BETA_NUM
                     && i_char == w_sep && i_ctl.saw_digit) begin
            case (i_ctl.phase)
                PH_MAJOR: begin
                    w_major     = i_accum;
                    w_ctl.phase = PH_MINOR;
                end
                PH_MINOR: begin
                    w_minor     = i_accum;
                    w_ctl.phase = PH_PATCH;
                end
                default: begin
                    w_patch     = i_accum;
                    w_ctl.phase = PH_SUFFIX;
                end
            endcase
            w_accum         = '0;
            w_ctl.saw_digit = 1'b0;
        end else if (w_num_phase) begin
            w_ctl.phase = PH_FAIL;
        end else begin
            case (i_ctl.phase)
                PH_SUFFIX: begin
                    if (i_char == stable_char(3'd0)) begin
                        w_ctl.phase   = PH_STABLE;
                        w_ctl.lit_idx = 3'd1;
                    end else if (i_char == beta_char(3'd0)) begin
                        w_ctl.phase   = PH_BETA_LIT;
                        w_ctl.lit_idx = 3'd1;
                    end else begin
                        w_ctl.phase = PH_FAIL;
                    end
                end
                PH_STABLE: begin
                    if (i_ctl.lit_idx < STABLE_LEN && i_char == stable_char(i_ctl.lit_idx)) begin
                        w_ctl.lit_idx = i_ctl.lit_idx + 3'd1;
                        if (w_ctl.lit_idx == STABLE_LEN) begin
                            w_ctl.phase = PH_DONE_STABLE;
                        end
                    end else begin
                        w_ctl.phase = PH_FAIL;
                    end
                end
                PH_BETA_LIT: begin
                    if (i_ctl.lit_idx < BETA_LEN && i_char == beta_char(i_ctl.lit_idx)) begin
                        w_ctl.lit_idx = i_ctl.lit_idx + 3'd1;
                        if (w_ctl.lit_idx == BETA_LEN) begin
                            w_ctl.phase = PH_BETA_NUM;
                        end
                    end else begin
                        w_ctl.phase = PH_FAIL;
                    end
                end
                default: begin
                    w_ctl.phase = PH_FAIL;
                end
            endcase
        end
    end

    assign w_ok_stable = (w_ctl.phase == PH_DONE_STABLE);
    assign w_ok_beta   = (w_ctl.phase == PH_BETA_NUM) && w_ctl.saw_digit;

    assign w_ext_major = {{OUT_W{1'b0}}, w_major};
    assign w_ext_minor = {{OUT_W{1'b0}}, w_minor};
    assign w_ext_patch = {{OUT_W{1'b0}}, w_patch};
    assign w_ext_beta  = {{OUT_W{1'b0}}, w_accum};
    assign w_out_beta  = w_ok_beta ? w_ext_beta[OUT_W-1:0] : '0;

    always_comb begin
        o_data = '0;
        o_user = '0;
        if (w_ok_stable || w_ok_beta) begin
            o_data = {{(DATA_W-4*OUT_W){1'b0}}, w_out_beta, w_ext_patch[OUT_W-1:0],
                      w_ext_minor[OUT_W-1:0], w_ext_major[OUT_W-1:0]};
            o_user = {w_ok_stable, 1'b1};
        end
    end

    // the final character returns everything to the reset state
    always_comb begin
        if (i_last) begin
            o_ctl   = '{phase: PH_MAJOR, lit_idx: 3'd0, saw_digit: 1'b0};
            o_accum = '0;
            o_major = '0;
            o_minor = '0;
            o_patch = '0;
        end else if (i_ctl.phase == PH_FAIL) begin
            o_ctl   = i_ctl;
            o_accum = i_accum;
            o_major = i_major;
            o_minor = i_minor;
            o_patch = i_patch;
        end else begin
            o_ctl   = w_ctl;
            o_accum = w_accum;
            o_major = w_major;
            o_minor = w_minor;
            o_patch = w_patch;
        end
    end

endmodule

[hdl/version_string_parser.sv]
// The result of a string is registered when its final item is accepted and offered in the next cycle.
// Throughput: one item per cycle; the parse state and the result register update together.
// A result waiting downstream stalls intake only while i_m_tready is low.
// Reset (i_rst_n low, synchronous): parse state returns to expecting the first major
// digit, numbers clear to zero and no result is offered.
module version_string_parser import vsp_pkg::*; #(
    parameter int NUM_BITS = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] char_code
    input  logic              i_s_tlast,   // last_char
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,   // major_num, minor_num, patch_num, beta_num, pad
    output logic [USER_W-1:0] o_m_tuser    // parse_ok, is_stable
);

    t_ctl                r_ctl, n_ctl;
    logic [NUM_BITS-1:0] r_accum, n_accum;
    logic [NUM_BITS-1:0] r_major, n_major;
    logic [NUM_BITS-1:0] r_minor, n_minor;
    logic [NUM_BITS-1:0] r_patch, n_patch;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic [USER_W-1:0]   r_out_user, n_out_user;
    logic                w_accept;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    vsp_step #(.NUM_BITS(NUM_BITS)) u_step (
        .i_ctl   (r_ctl),
        .i_accum (r_accum),
        .i_major (r_major),
        .i_minor (r_minor),
        .i_patch (r_patch),
        .i_char  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_ctl   (n_ctl),
        .o_accum (n_accum),
        .o_major (n_major),
        .o_minor (n_minor),
        .o_patch (n_patch),
        .o_data  (n_out_data),
        .o_user  (n_out_user)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '{phase: PH_MAJOR, lit_idx: 3'd0, saw_digit: 1'b0};
            r_accum     <= '0;
            r_major     <= '0;
            r_minor     <= '0;
            r_patch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_ctl   <= n_ctl;
                r_accum <= n_accum;
                r_major <= n_major;
                r_minor <= n_minor;
                r_patch <= n_patch;
            end
            if (w_accept && i_s_tlast) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_s_tlast) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule
